// ===== hw/rtl/ppe_pkg.sv =====
// ----------------------------------------------------------------------------
// ppe_pkg
// Shared types and constants of the particle pool engine.
// ----------------------------------------------------------------------------
package ppe_pkg;

  localparam int unsigned CountW = 7;

  typedef enum logic [1:0] {
    CMD_SPAWN  = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_DRAW   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_VERTEX = 2'd1,
    KIND_EMPTY  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1,
    REG_GRAVITY       = 2'd2
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPAWN,
    ST_CLEAR,
    ST_DONE,
    ST_UPD_PREP,
    ST_UPD_SCAN,
    ST_UPD_VY,
    ST_UPD_MUL,
    ST_UPD_WB,
    ST_UPD_FIN,
    ST_DRAW_SCAN,
    ST_DRAW_DIV,
    ST_DRAW_WAIT,
    ST_DRAW_OUT,
    ST_DRAW_EMPTY
  } state_e;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic [23:0]        color;
    logic [15:0]        life;
    logic [15:0]        max_life;
  } slot_t;

  typedef struct packed {
    logic  lat_in;
    logic  idx_clr;
    logic  idx_inc;
    logic  mem_rd;
    logic  spawn_wr;
    logic  drop_set;
    logic  clr_all;
    logic  gstep_ld;
    logic  upd_vy;
    logic  upd_mul;
    logic  upd_wb;
    logic  total_ld;
    logic  div_start;
    logic  out_ld;
    kind_e out_kind;
  } ctrl_cmd_t;

  typedef struct packed {
    logic cur_active;
    logic idx_last;
    logic div_done;
    logic out_free;
    logic last_vert;
  } ctrl_sts_t;

endpackage

// ===== hw/rtl/particle_pool_engine_top.sv =====
// ----------------------------------------------------------------------------
// particle_pool_engine_top
// Fixed pool of screen-space particles driven by spawn, update, clear, draw.
// ----------------------------------------------------------------------------
// One command is taken at a time; the next item is stalled until the current
// one has handed its last result to the output register. Slots are visited one
// per cycle through a single-port slot memory with registered read, unless an
// update or draw is working on an active slot. Spawn searches for the lowest
// free slot; update adds gravity, multiplies and writes back each active slot
// after its read; draw runs the bit-serial alpha divider for each active slot.
// Results wait in a one-entry output register.
module particle_pool_engine_top import ppe_pkg::*; #(
  parameter int unsigned POOL_SIZE = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         cmd_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic signed [15:0] vel_x_i,
  input  logic signed [15:0] vel_y_i,
  input  logic [23:0]        base_color_i,
  input  logic [15:0]        lifetime_i,
  input  logic [15:0]        delta_time_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         kind_o,
  output logic signed [15:0] vert_x_o,
  output logic signed [15:0] vert_y_o,
  output logic [31:0]        vert_color_o,
  output logic [6:0]         live_count_o,
  output logic               spawn_dropped_o,
  output logic               last_o
);

  ctrl_cmd_t ctrl_cmd;
  ctrl_sts_t ctrl_sts;

  ppe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .sts_i      (ctrl_sts),
    .cmd_o      (ctrl_cmd)
  );

  ppe_dpath #(
    .POOL_SIZE (POOL_SIZE)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .vel_x_i         (vel_x_i),
    .vel_y_i         (vel_y_i),
    .base_color_i    (base_color_i),
    .lifetime_i      (lifetime_i),
    .delta_time_i    (delta_time_i),
    .cmd_i           (ctrl_cmd),
    .sts_o           (ctrl_sts),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .vert_x_o        (vert_x_o),
    .vert_y_o        (vert_y_o),
    .vert_color_o    (vert_color_o),
    .live_count_o    (live_count_o),
    .spawn_dropped_o (spawn_dropped_o),
    .last_o          (last_o)
  );

endmodule

// ===== hw/rtl/ppe_div.sv =====
// ----------------------------------------------------------------------------
// ppe_div
// Alpha unit: floor(255*life/max_life) clamped to 255, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module ppe_div import ppe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] life_i,
  input  logic [15:0] max_i,
  output logic        done_o,
  output logic [7:0]  alpha_o
);

  logic [3:0]  cnt_q, cnt_d;
  logic [15:0] rem_q, rem_d;
  logic [15:0] den_q, den_d;
  logic [7:0]  num_q, num_d;
  logic [7:0]  quo_q, quo_d;
  logic        sat_q, sat_d;
  logic [23:0] prod;
  logic [16:0] rem_sh;

  assign prod   = {life_i, 8'd0} - {8'd0, life_i};
  assign rem_sh = {rem_q, num_q[7]};

  always_comb begin
    cnt_d = cnt_q;
    rem_d = rem_q;
    den_d = den_q;
    num_d = num_q;
    quo_d = quo_q;
    sat_d = sat_q;
    if (start_i) begin
      cnt_d = 4'd8;
      rem_d = prod[23:8];
      num_d = prod[7:0];
      den_d = max_i;
      quo_d = 8'd0;
      sat_d = (life_i >= max_i);
    end else if (cnt_q != 4'd0) begin
      cnt_d = cnt_q - 4'd1;
      num_d = {num_q[6:0], 1'b0};
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d = 16'(rem_sh - {1'b0, den_q});
        quo_d = {quo_q[6:0], 1'b1};
      end else begin
        rem_d = rem_sh[15:0];
        quo_d = {quo_q[6:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 4'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    num_q <= num_d;
    quo_q <= quo_d;
    sat_q <= sat_d;
  end

  assign done_o  = (cnt_q == 4'd0);
  assign alpha_o = sat_q ? 8'd255 : quo_q;

endmodule

// ===== hw/rtl/ppe_ctrl.sv =====
// ----------------------------------------------------------------------------
// ppe_ctrl
// Command sequencer: walks the pool slots and steps the datapath.
// ----------------------------------------------------------------------------
module ppe_ctrl import ppe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] cmd_i,
  input  ctrl_sts_t  sts_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;
  cmd_e   cmd_in;

  assign cmd_in = cmd_e'(cmd_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (cmd_in)
            CMD_SPAWN:  state_d = ST_SPAWN;
            CMD_UPDATE: state_d = ST_UPD_PREP;
            CMD_CLEAR:  state_d = ST_CLEAR;
            default:    state_d = ST_DRAW_SCAN;
          endcase
        end
      end
      ST_SPAWN: begin
        if (!sts_i.cur_active || sts_i.idx_last) state_d = ST_DONE;
      end
      ST_CLEAR:    state_d = ST_DONE;
      ST_DONE: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      ST_UPD_PREP: state_d = ST_UPD_SCAN;
      ST_UPD_SCAN: begin
        if (sts_i.cur_active) state_d = ST_UPD_VY;
        else if (sts_i.idx_last) state_d = ST_UPD_FIN;
      end
      ST_UPD_VY:  state_d = ST_UPD_MUL;
      ST_UPD_MUL: state_d = ST_UPD_WB;
      ST_UPD_WB:  state_d = sts_i.idx_last ? ST_UPD_FIN : ST_UPD_SCAN;
      ST_UPD_FIN: state_d = ST_DONE;
      ST_DRAW_SCAN: begin
        if (sts_i.cur_active) state_d = ST_DRAW_DIV;
        else if (sts_i.idx_last) state_d = ST_DRAW_EMPTY;
      end
      ST_DRAW_DIV:  state_d = ST_DRAW_WAIT;
      ST_DRAW_WAIT: begin
        if (sts_i.div_done) state_d = ST_DRAW_OUT;
      end
      ST_DRAW_OUT: begin
        if (sts_i.out_free) begin
          state_d = (sts_i.last_vert || sts_i.idx_last) ? ST_IDLE : ST_DRAW_SCAN;
        end
      end
      ST_DRAW_EMPTY: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.out_kind = KIND_STATUS;
    case (state_q)
      ST_IDLE: begin
        cmd_o.lat_in  = in_valid_i;
        cmd_o.idx_clr = in_valid_i;
      end
      ST_SPAWN: begin
        if (!sts_i.cur_active) cmd_o.spawn_wr = 1'b1;
        else if (sts_i.idx_last) cmd_o.drop_set = 1'b1;
        else cmd_o.idx_inc = 1'b1;
      end
      ST_CLEAR: cmd_o.clr_all = 1'b1;
      ST_DONE:  cmd_o.out_ld = sts_i.out_free;
      ST_UPD_PREP: cmd_o.gstep_ld = 1'b1;
      ST_UPD_SCAN: begin
        if (sts_i.cur_active) cmd_o.mem_rd = 1'b1;
        else if (!sts_i.idx_last) cmd_o.idx_inc = 1'b1;
      end
      ST_UPD_VY:  cmd_o.upd_vy = 1'b1;
      ST_UPD_MUL: cmd_o.upd_mul = 1'b1;
      ST_UPD_WB: begin
        cmd_o.upd_wb  = 1'b1;
        cmd_o.idx_inc = !sts_i.idx_last;
      end
      ST_UPD_FIN: cmd_o.total_ld = 1'b1;
      ST_DRAW_SCAN: begin
        if (sts_i.cur_active) cmd_o.mem_rd = 1'b1;
        else if (!sts_i.idx_last) cmd_o.idx_inc = 1'b1;
      end
      ST_DRAW_DIV: cmd_o.div_start = 1'b1;
      ST_DRAW_OUT: begin
        cmd_o.out_kind = KIND_VERTEX;
        cmd_o.out_ld   = sts_i.out_free;
        cmd_o.idx_inc  = sts_i.out_free && !sts_i.idx_last;
      end
      ST_DRAW_EMPTY: begin
        cmd_o.out_kind = KIND_EMPTY;
        cmd_o.out_ld   = sts_i.out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

// ===== hw/rtl/ppe_dpath.sv =====
// ----------------------------------------------------------------------------
// ppe_dpath
// Slot memory, active flags, motion arithmetic, alpha unit and result register.
// ----------------------------------------------------------------------------
module ppe_dpath import ppe_pkg::*; #(
  parameter int unsigned POOL_SIZE = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic signed [15:0] vel_x_i,
  input  logic signed [15:0] vel_y_i,
  input  logic [23:0]        base_color_i,
  input  logic [15:0]        lifetime_i,
  input  logic [15:0]        delta_time_i,
  input  ctrl_cmd_t          cmd_i,
  output ctrl_sts_t          sts_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         kind_o,
  output logic signed [15:0] vert_x_o,
  output logic signed [15:0] vert_y_o,
  output logic [31:0]        vert_color_o,
  output logic [6:0]         live_count_o,
  output logic               spawn_dropped_o,
  output logic               last_o
);

  localparam int unsigned IdxW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;

  logic [10:0] width_q, height_q;
  logic [15:0] grav_q;

  slot_t mem_q [POOL_SIZE];
  slot_t rd_q, wdata, spawn_word, upd_word;
  logic  mem_we;

  logic [POOL_SIZE-1:0] act_q, act_d;
  logic [IdxW-1:0]      idx_q, idx_d;
  logic [CountW-1:0]    total_q, total_d, cnt_q, cnt_d;

  logic signed [15:0] in_px_q, in_py_q, in_vx_q, in_vy_q;
  logic [23:0]        in_col_q;
  logic [15:0]        in_life_q, dt_q;
  logic               drop_q;

  logic [31:0]        gprod;
  logic [21:0]        gstep_q;
  logic signed [23:0] vy_full;
  logic signed [15:0] vy_sat, vy_q;
  logic signed [32:0] px_q, py_q;
  logic signed [23:0] nx, ny;
  logic [14:0]        wlim, hlim;
  logic               on_x, on_y, dead, alive;

  logic       div_done;
  logic [7:0] alpha;

  logic                out_valid_q;
  kind_e               kind_q;
  logic signed [15:0]  vx_out_q, vy_out_q;
  logic [31:0]         col_out_q;
  logic [6:0]          live_q;
  logic                dropped_q, last_q;
  logic                last_vert;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 11'd640;
      height_q <= 11'd480;
      grav_q   <= 16'd4800;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        REG_SCREEN_WIDTH:  width_q  <= cfg_data_i[10:0];
        REG_SCREEN_HEIGHT: height_q <= cfg_data_i[10:0];
        REG_GRAVITY:       grav_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lat_in) begin
      in_px_q   <= pos_x_i;
      in_py_q   <= pos_y_i;
      in_vx_q   <= vel_x_i;
      in_vy_q   <= vel_y_i;
      in_col_q  <= base_color_i;
      in_life_q <= lifetime_i;
      dt_q      <= delta_time_i;
    end
  end

  assign gprod = 32'(grav_q) * 32'(dt_q);

  assign vy_full = 24'(rd_q.vel_y) + 24'($signed({2'b00, gstep_q}));
  always_comb begin
    if (vy_full > 24'sd32767) vy_sat = 16'sd32767;
    else if (vy_full < -24'sd32768) vy_sat = -16'sd32768;
    else vy_sat = vy_full[15:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.gstep_ld) gstep_q <= gprod[31:10];
    if (cmd_i.upd_vy) vy_q <= vy_sat;
    if (cmd_i.upd_mul) begin
      px_q <= rd_q.vel_x * $signed({1'b0, dt_q});
      py_q <= vy_q * $signed({1'b0, dt_q});
    end
  end

  assign nx    = 24'(rd_q.pos_x) + 24'($signed(px_q[32:10]));
  assign ny    = 24'(rd_q.pos_y) + 24'($signed(py_q[32:10]));
  assign wlim  = {width_q, 4'd0};
  assign hlim  = {height_q, 4'd0};
  assign on_x  = !nx[23] && (nx[22:0] < 23'(wlim));
  assign on_y  = !ny[23] && (ny[22:0] < 23'(hlim));
  assign dead  = (dt_q >= rd_q.life);
  assign alive = !dead && on_x && on_y;

  always_comb begin
    spawn_word.pos_x    = in_px_q;
    spawn_word.pos_y    = in_py_q;
    spawn_word.vel_x    = in_vx_q;
    spawn_word.vel_y    = in_vy_q;
    spawn_word.color    = in_col_q;
    spawn_word.life     = in_life_q;
    spawn_word.max_life = (in_life_q != 16'd0) ? in_life_q : 16'd1;
    upd_word            = rd_q;
    upd_word.pos_x      = nx[15:0];
    upd_word.pos_y      = ny[15:0];
    upd_word.vel_y      = vy_q;
    upd_word.life       = dead ? 16'd0 : 16'(rd_q.life - dt_q);
  end

  assign mem_we = cmd_i.spawn_wr || cmd_i.upd_wb;
  assign wdata  = cmd_i.spawn_wr ? spawn_word : upd_word;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[idx_q] <= wdata;
    if (cmd_i.mem_rd) rd_q <= mem_q[idx_q];
  end

  assign last_vert = (7'(cnt_q + 7'd1) == total_q);

  always_comb begin
    act_d   = act_q;
    idx_d   = idx_q;
    total_d = total_q;
    cnt_d   = cnt_q;
    if (cmd_i.idx_clr) idx_d = '0;
    else if (cmd_i.idx_inc) idx_d = IdxW'(idx_q + 1'b1);
    if (cmd_i.lat_in) cnt_d = '0;
    else if ((cmd_i.upd_wb && alive) ||
             (cmd_i.out_ld && (cmd_i.out_kind == KIND_VERTEX))) begin
      cnt_d = 7'(cnt_q + 7'd1);
    end
    if (cmd_i.spawn_wr) begin
      act_d[idx_q] = 1'b1;
      total_d      = 7'(total_q + 7'd1);
    end
    if (cmd_i.upd_wb && !alive) act_d[idx_q] = 1'b0;
    if (cmd_i.total_ld) total_d = cnt_q;
    if (cmd_i.clr_all) begin
      act_d   = '0;
      total_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q   <= '0;
      idx_q   <= '0;
      total_q <= '0;
      cnt_q   <= '0;
      drop_q  <= 1'b0;
    end else begin
      act_q   <= act_d;
      idx_q   <= idx_d;
      total_q <= total_d;
      cnt_q   <= cnt_d;
      if (cmd_i.lat_in) drop_q <= 1'b0;
      else if (cmd_i.drop_set) drop_q <= 1'b1;
    end
  end

  ppe_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .life_i  (rd_q.life),
    .max_i   (rd_q.max_life),
    .done_o  (div_done),
    .alpha_o (alpha)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      kind_q    <= cmd_i.out_kind;
      live_q    <= total_q;
      dropped_q <= (cmd_i.out_kind == KIND_STATUS) && drop_q;
      if (cmd_i.out_kind == KIND_VERTEX) begin
        vx_out_q  <= rd_q.pos_x;
        vy_out_q  <= rd_q.pos_y;
        col_out_q <= {alpha, rd_q.color};
        last_q    <= last_vert;
      end else begin
        vx_out_q  <= '0;
        vy_out_q  <= '0;
        col_out_q <= '0;
        last_q    <= 1'b1;
      end
    end
  end

  assign sts_o.cur_active = act_q[idx_q];
  assign sts_o.idx_last   = (idx_q == IdxW'(POOL_SIZE - 1));
  assign sts_o.div_done   = div_done;
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;
  assign sts_o.last_vert  = last_vert;

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign vert_x_o        = vx_out_q;
  assign vert_y_o        = vy_out_q;
  assign vert_color_o    = col_out_q;
  assign live_count_o    = live_q;
  assign spawn_dropped_o = dropped_q;
  assign last_o          = last_q;

endmodule

// ===== verif/tb_particle_pool_engine_top.sv =====
// ----------------------------------------------------------------------------
// tb_particle_pool_engine_top
// Self-checking bench for the particle pool engine: spawn, update, clear and
// draw items are predicted against an in-bench pool model, results checked in
// order under random idling on both channels and several screen settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_particle_pool_engine_top;
  import ppe_pkg::*;

  localparam int unsigned Pool = 64;
  localparam longint CycleLimit = 3_000_000;

  typedef struct {
    cmd_e        cmd;
    logic [15:0] pos_x, pos_y, vel_x, vel_y;
    logic [23:0] color;
    logic [15:0] lifetime, dt;
  } pkt_t;

  typedef struct {
    kind_e       kind;
    logic [15:0] x, y;
    logic [31:0] color;
    logic [6:0]  count;
    logic        dropped, last;
  } vtx_t;

  logic clk_i = 1'b0, rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0, in_stall_o;
  logic [1:0] cmd_i = '0;
  logic signed [15:0] pos_x_i = '0, pos_y_i = '0, vel_x_i = '0, vel_y_i = '0;
  logic [23:0] base_color_i = '0;
  logic [15:0] lifetime_i = '0, delta_time_i = '0;
  logic out_valid_o, out_stall_i = 1'b0;
  logic [1:0] kind_o;
  logic signed [15:0] vert_x_o, vert_y_o;
  logic [31:0] vert_color_o;
  logic [6:0] live_count_o;
  logic spawn_dropped_o, last_o;

  particle_pool_engine_top #(.POOL_SIZE(Pool)) i_dut (.*);

  // pool shadow
  bit          act[Pool];
  longint      px[Pool], py[Pool], vx[Pool], vy[Pool], life[Pool], mlife[Pool];
  logic [23:0] col[Pool];
  longint      total;
  longint      scr_w = 640, scr_h = 480, grav = 4800;

  pkt_t pending[$];
  vtx_t want[$];
  int   mismatches = 0;
  int   send_idle = 0, recv_idle = 0;
  bit   drain_gate = 1'b0;
  bit   taken = 1'b0;
  longint cycles = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [15:0] r16();
    return 16'($urandom);
  endfunction

  function automatic logic [23:0] r24();
    return 24'($urandom);
  endfunction

  function automatic void add_want(kind_e k, longint x, longint y, logic [31:0] c,
                                   bit d, bit l);
    vtx_t v;
    v.kind = k; v.x = x[15:0]; v.y = y[15:0]; v.color = c;
    v.count = total[6:0]; v.dropped = d; v.last = l;
    want.push_back(v);
  endfunction

  function automatic void run_pool(pkt_t p);
    int i, n;
    longint dt, nvy, nx, ny, alpha;
    bit dead;
    case (p.cmd)
      CMD_SPAWN: begin
        for (i = 0; i < Pool; i++) if (!act[i]) break;
        if (i >= Pool) begin
          add_want(KIND_STATUS, 0, 0, 0, 1'b1, 1'b1);
        end else begin
          px[i] = $signed(p.pos_x); py[i] = $signed(p.pos_y);
          vx[i] = $signed(p.vel_x); vy[i] = $signed(p.vel_y);
          col[i] = p.color; life[i] = p.lifetime;
          mlife[i] = (p.lifetime > 0) ? p.lifetime : 1;
          act[i] = 1'b1; total++;
          add_want(KIND_STATUS, 0, 0, 0, 1'b0, 1'b1);
        end
      end
      CMD_UPDATE: begin
        dt = p.dt; n = 0;
        for (i = 0; i < Pool; i++) begin
          if (!act[i]) continue;
          nvy = vy[i] + ((grav * dt) >>> 10);
          if (nvy > 32767) nvy = 32767;
          if (nvy < -32768) nvy = -32768;
          vy[i] = nvy;
          nx = px[i] + ((vx[i] * dt) >>> 10);
          ny = py[i] + ((nvy * dt) >>> 10);
          dead = dt >= life[i];
          life[i] = dead ? 0 : life[i] - dt;
          if (dead || nx < 0 || nx >= scr_w * 16 || ny < 0 || ny >= scr_h * 16) begin
            act[i] = 1'b0;
            continue;
          end
          px[i] = nx; py[i] = ny; n++;
        end
        total = n;
        add_want(KIND_STATUS, 0, 0, 0, 1'b0, 1'b1);
      end
      CMD_CLEAR: begin
        for (i = 0; i < Pool; i++) act[i] = 1'b0;
        total = 0;
        add_want(KIND_STATUS, 0, 0, 0, 1'b0, 1'b1);
      end
      default: begin
        n = 0;
        for (i = 0; i < Pool; i++) begin
          if (!act[i]) continue;
          alpha = (life[i] * 255) / mlife[i];
          if (alpha > 255) alpha = 255;
          add_want(KIND_VERTEX, px[i], py[i], {alpha[7:0], col[i]}, 1'b0, 1'b0);
          n++;
        end
        if (n == 0) add_want(KIND_EMPTY, 0, 0, 0, 1'b0, 1'b1);
        else want[want.size() - 1].last = 1'b1;
      end
    endcase
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      taken = 1'b1;
      run_pool(pending.pop_front());
    end
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (!in_valid_i || taken) begin
      taken = 1'b0;
      if (pending.size() != 0 && !(drain_gate && want.size() != 0) &&
          $urandom_range(0, 99) >= send_idle) begin
        cmd_i <= pending[0].cmd;
        pos_x_i <= pending[0].pos_x; pos_y_i <= pending[0].pos_y;
        vel_x_i <= pending[0].vel_x; vel_y_i <= pending[0].vel_y;
        base_color_i <= pending[0].color;
        lifetime_i <= pending[0].lifetime; delta_time_i <= pending[0].dt;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= ($urandom_range(0, 99) < recv_idle);
  end

  // monitor
  always @(posedge clk_i) begin
    vtx_t e;
    if (out_valid_o && !out_stall_i) begin
      if (want.size() == 0) begin
        $error("result with nothing expected: kind %0d", kind_o);
        mismatches++;
      end else begin
        e = want.pop_front();
        if (kind_o !== e.kind) begin
          $error("kind exp %0d got %0d", e.kind, kind_o); mismatches++;
        end
        if (vert_x_o !== e.x) begin
          $error("vert_x exp %0d got %0d", $signed(e.x), vert_x_o); mismatches++;
        end
        if (vert_y_o !== e.y) begin
          $error("vert_y exp %0d got %0d", $signed(e.y), vert_y_o); mismatches++;
        end
        if (vert_color_o !== e.color) begin
          $error("vert_color exp %h got %h", e.color, vert_color_o); mismatches++;
        end
        if (live_count_o !== e.count) begin
          $error("live_count exp %0d got %0d", e.count, live_count_o); mismatches++;
        end
        if (spawn_dropped_o !== e.dropped) begin
          $error("spawn_dropped exp %0d got %0d", e.dropped, spawn_dropped_o);
          mismatches++;
        end
        if (last_o !== e.last) begin
          $error("last exp %0d got %0d", e.last, last_o); mismatches++;
        end
      end
    end
  end

  task automatic add_pkt(cmd_e c, logic [15:0] x, logic [15:0] y, logic [15:0] vx_,
                         logic [15:0] vy_, logic [23:0] cl, logic [15:0] lf,
                         logic [15:0] d);
    pkt_t p;
    p.cmd = c; p.pos_x = x; p.pos_y = y; p.vel_x = vx_; p.vel_y = vy_;
    p.color = cl; p.lifetime = lf; p.dt = d;
    pending.push_back(p);
  endtask

  task automatic drain();
    wait (pending.size() == 0 && want.size() == 0);
    @(posedge clk_i);
    wait (!in_valid_i && want.size() == 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e r, logic [15:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= r; cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (r)
      REG_SCREEN_WIDTH:  scr_w = v[10:0];
      REG_SCREEN_HEIGHT: scr_h = v[10:0];
      default:           grav = v;
    endcase
  endtask

  task automatic spawn_rand();
    logic [15:0] x, y, l;
    if ($urandom_range(0, 3) == 0) begin
      x = r16(); y = r16();
    end else begin
      x = 16'($urandom_range(0, int'(scr_w * 16 > 0 ? scr_w * 16 - 1 : 0)));
      y = 16'($urandom_range(0, int'(scr_h * 16 > 0 ? scr_h * 16 - 1 : 0)));
    end
    l = ($urandom_range(0, 3) == 0) ? r16() : 16'($urandom_range(0, 3000));
    add_pkt(CMD_SPAWN, x, y, ($urandom_range(0, 3) == 0) ? r16() :
            16'($signed($urandom_range(0, 2000)) - 1000), r16(), r24(), l,
            r16());
  endtask

  task automatic rand_items(int n);
    int k;
    repeat (n) begin
      k = $urandom_range(0, 99);
      if (k < 50) spawn_rand();
      else if (k < 75)
        add_pkt(CMD_UPDATE, r16(), r16(), r16(), r16(), r24(),
                r16(), ($urandom_range(0, 4) == 0) ? r16() :
                16'($urandom_range(0, 64)));
      else if (k < 95)
        add_pkt(CMD_DRAW, r16(), r16(), r16(), r16(), r24(), r16(), r16());
      else
        add_pkt(CMD_CLEAR, r16(), r16(), r16(), r16(), r24(), r16(), r16());
    end
  endtask

  initial begin
    foreach (act[i]) act[i] = 1'b0;
    total = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    send_idle = 11; recv_idle = 68;
    add_pkt(CMD_DRAW, 0, 0, 0, 0, 0, 0, 0);
    add_pkt(CMD_SPAWN, 16'h0000, 16'h0000, 16'h7fff, 16'h8000, 24'hffffff, 16'hffff, 0);
    add_pkt(CMD_SPAWN, 10239, 7679, 16'h8000, 16'h7fff, 24'h000000, 0, 16'hffff);
    add_pkt(CMD_SPAWN, 16'h7fff, 16'h8000, 0, 0, 24'h123456, 1, 0);
    add_pkt(CMD_SPAWN, 160, 160, 16, 16'hfff0, 24'habcdef, 1000, 0);
    add_pkt(CMD_SPAWN, 5000, 100, 0, 16'h7f00, 24'h55aa55, 5000, 0);
    add_pkt(CMD_DRAW, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 24'hffffff, 16'hffff,
            16'hffff);
    add_pkt(CMD_UPDATE, 0, 0, 0, 0, 0, 0, 0);
    add_pkt(CMD_DRAW, 0, 0, 0, 0, 0, 0, 0);
    add_pkt(CMD_UPDATE, 0, 0, 0, 0, 0, 0, 300);
    add_pkt(CMD_DRAW, 0, 0, 0, 0, 0, 0, 0);
    add_pkt(CMD_UPDATE, 0, 0, 0, 0, 0, 0, 16'hffff);
    add_pkt(CMD_DRAW, 0, 0, 0, 0, 0, 0, 0);
    add_pkt(CMD_SPAWN, 320, 320, 0, 0, 24'h00ff00, 700, 0);
    add_pkt(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0);
    add_pkt(CMD_DRAW, 0, 0, 0, 0, 0, 0, 0);
    drain();

    write_reg(REG_GRAVITY, 16'hffff);
    write_reg(REG_SCREEN_WIDTH, 2047);
    write_reg(REG_SCREEN_HEIGHT, 2047);
    // fill the pool, overflow it, then age it
    repeat (66) spawn_rand();
    add_pkt(CMD_DRAW, 0, 0, 0, 0, 0, 0, 0);
    add_pkt(CMD_UPDATE, 0, 0, 0, 0, 0, 0, 20);
    add_pkt(CMD_DRAW, 0, 0, 0, 0, 0, 0, 0);
    rand_items(30);
    drain();

    send_idle = 68; recv_idle = 11;
    write_reg(REG_SCREEN_WIDTH, 1);
    write_reg(REG_SCREEN_HEIGHT, 1);
    write_reg(REG_GRAVITY, 0);
    rand_items(30);
    drain();
    write_reg(REG_SCREEN_WIDTH, 0);
    write_reg(REG_SCREEN_HEIGHT, 0);
    drain_gate = 1'b1;
    rand_items(12);
    drain();
    drain_gate = 1'b0;

    send_idle = 0; recv_idle = 0;
    write_reg(REG_SCREEN_WIDTH, 640);
    write_reg(REG_SCREEN_HEIGHT, 480);
    write_reg(REG_GRAVITY, 4800);
    rand_items(73);
    drain();

    repeat (200) @(posedge clk_i);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/ppe_pkg.sv
hw/rtl/ppe_div.sv
hw/rtl/ppe_ctrl.sv
hw/rtl/ppe_dpath.sv
hw/rtl/particle_pool_engine_top.sv
verif/tb_particle_pool_engine_top.sv
